// ===== src/altbl_pkg.sv =====
// Package with shared types, constants and command codes of the list engine.
`default_nettype none
package altbl_pkg;
  localparam int unsigned DefaultDepth = 1024;
  localparam int unsigned DefaultValueWidth = 32;
  localparam int unsigned KindWidth = 3;
  localparam int unsigned PosWidth = 11;
  localparam int unsigned InWidth = 32;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned IndexWidth = 10;
  localparam int unsigned CountWidth = 11;

  localparam logic [KindWidth-1:0] KindInsert = 3'd0;
  localparam logic [KindWidth-1:0] KindDelete = 3'd1;
  localparam logic [KindWidth-1:0] KindFind = 3'd2;
  localparam logic [KindWidth-1:0] KindCount = 3'd3;
  localparam logic [KindWidth-1:0] KindDedup = 3'd4;
  localparam logic [KindWidth-1:0] KindRangeDel = 3'd5;

  localparam logic [StatusWidth-1:0] StatusOk = 2'd0;
  localparam logic [StatusWidth-1:0] StatusBadPos = 2'd1;
  localparam logic [StatusWidth-1:0] StatusFull = 2'd2;
  localparam logic [StatusWidth-1:0] StatusNotFound = 2'd3;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OpNone, OpLatch, OpJInit, OpKInit, OpRdJ, OpRdK, OpWrBack, OpWrVal,
    OpJDec, OpJInc, OpKInc, OpCmpScan, OpDedupKeep, OpCmpRange, OpFinish
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [KindWidth-1:0] kind;
    logic                 full;
    logic                 pos_bad_ins;
    logic                 pos_bad_del;
    logic                 j_done;   // scan/shift index reached its end
    logic                 k_done;   // inner dedup index reached write count
    logic                 match;    // registered read equals reference or lies in range
  } dp_status_t;
endpackage
`default_nettype wire

// ===== src/altbl_if.sv =====
// Valid/ready channel interfaces for commands and results.
`default_nettype none
interface altbl_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [altbl_pkg::KindWidth-1:0]      kind;
  logic [altbl_pkg::PosWidth-1:0]       position;
  logic signed [altbl_pkg::InWidth-1:0] value;
  logic signed [altbl_pkg::InWidth-1:0] range_high;
  modport source (output valid, kind, position, value, range_high, input ready);
  modport sink (input valid, kind, position, value, range_high, output ready);
endinterface

interface altbl_res_if;
  logic                                   valid;
  logic                                   ready;
  logic [altbl_pkg::StatusWidth-1:0]      status;
  logic [altbl_pkg::IndexWidth-1:0]       found_index;
  logic [altbl_pkg::CountWidth-1:0]       range_count;
  logic [altbl_pkg::CountWidth-1:0]       list_length;
  modport source (output valid, status, found_index, range_count, list_length,
                  input ready);
  modport sink (input valid, status, found_index, range_count, list_length,
                output ready);
endinterface
`default_nettype wire

// ===== src/array_list_table_engine_top.sv =====
// Top level of the ordered list engine.
// One command item is taken at a time and gives one result item. Each command
// walks the list through the list memory, stepping each entry touched through
// read, registered read data, act and advance, and range delete adds a compare
// step; insert also writes the new value. Find stops at the first match,
// deduplicate also rescans the kept entries for each entry, reading and
// comparing each kept entry. A command that is rejected or of an unused kind
// gives its result without walking the list.
`default_nettype none
module array_list_table_engine_top #(
  parameter int unsigned Depth = altbl_pkg::DefaultDepth,
  parameter int unsigned ValueWidth = altbl_pkg::DefaultValueWidth
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  altbl_cmd_if.sink  cmd_i,
  altbl_res_if.source res_o
);
  altbl_pkg::dp_cmd_t    cmd;
  altbl_pkg::dp_status_t sts;

  altbl_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(cmd_i.valid), .in_ready_o(cmd_i.ready),
    .out_valid_o(res_o.valid), .out_ready_i(res_o.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  altbl_datapath #(.Depth(Depth), .ValueWidth(ValueWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .kind_i(cmd_i.kind), .position_i(cmd_i.position), .value_i(cmd_i.value),
    .range_high_i(cmd_i.range_high),
    .status_o(res_o.status), .found_index_o(res_o.found_index),
    .range_count_o(res_o.range_count), .list_length_o(res_o.list_length)
  );
endmodule
`default_nettype wire

// ===== src/altbl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module altbl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/altbl_datapath.sv =====
// Datapath: list memory, indexes, length register, comparators and result.
`default_nettype none
module altbl_datapath #(
  parameter int unsigned Depth = altbl_pkg::DefaultDepth,
  parameter int unsigned ValueWidth = altbl_pkg::DefaultValueWidth
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire altbl_pkg::dp_cmd_t                   cmd_i,
  output altbl_pkg::dp_status_t                     sts_o,
  input  wire logic [altbl_pkg::KindWidth-1:0]      kind_i,
  input  wire logic [altbl_pkg::PosWidth-1:0]       position_i,
  input  wire logic signed [altbl_pkg::InWidth-1:0] value_i,
  input  wire logic signed [altbl_pkg::InWidth-1:0] range_high_i,
  output logic [altbl_pkg::StatusWidth-1:0]         status_o,
  output logic [altbl_pkg::IndexWidth-1:0]          found_index_o,
  output logic [altbl_pkg::CountWidth-1:0]          range_count_o,
  output logic [altbl_pkg::CountWidth-1:0]          list_length_o
);
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned PW = (altbl_pkg::PosWidth > LW) ? altbl_pkg::PosWidth : LW;

  logic [altbl_pkg::KindWidth-1:0] kind_q;
  logic [PW-1:0]                   pos_q;
  logic signed [ValueWidth-1:0]    vkey_q;
  logic signed [altbl_pkg::InWidth-1:0] lo_q, hi_q;
  logic [LW-1:0] len_q, j_q, k_q, w_q, cnt_q;
  logic [altbl_pkg::StatusWidth-1:0] status_q;
  logic [LW-1:0] found_q;
  logic signed [ValueWidth-1:0] cur_q;  // entry held for copy or comparison
  logic rd_is_j_q;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [ValueWidth-1:0] wdata, rdata;
  logic signed [altbl_pkg::InWidth:0] rdata_x, lo_x, hi_x;
  logic in_range;
  logic [PW-1:0] len_ext;

  assign len_ext = PW'(len_q);
  assign rdata_x = (altbl_pkg::InWidth+1)'(signed'(rdata));
  assign lo_x = (altbl_pkg::InWidth+1)'(lo_q);
  assign hi_x = (altbl_pkg::InWidth+1)'(hi_q);
  assign in_range = (rdata_x >= lo_x) && (rdata_x <= hi_x);

  altbl_ram #(.Width(ValueWidth), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    we = 1'b0;
    waddr = j_q[AW-1:0];
    wdata = rdata;
    // The last read address is held so the read data stays valid while waiting.
    raddr = rd_is_j_q ? j_q[AW-1:0] : k_q[AW-1:0];
    case (cmd_i.op)
      altbl_pkg::OpRdK: raddr = k_q[AW-1:0];
      altbl_pkg::OpWrBack: begin
        we = 1'b1;
        // Insert shifts up (j <- j-1 read), delete shifts down, compaction to w.
        case (kind_q)
          altbl_pkg::KindInsert: waddr = j_q[AW-1:0];
          altbl_pkg::KindDelete: waddr = AW'(j_q - 1'b1);
          default:               waddr = w_q[AW-1:0];
        endcase
        wdata = cur_q;
      end
      altbl_pkg::OpWrVal: begin
        we = 1'b1;
        waddr = AW'(pos_q - 1'b1);
        wdata = vkey_q;
      end
      altbl_pkg::OpRdJ: begin
        if (kind_q == altbl_pkg::KindInsert) raddr = AW'(j_q - 1'b1);
        else raddr = j_q[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      kind_q <= '0;
      j_q <= '0;
      k_q <= '0;
      w_q <= '0;
      cnt_q <= '0;
      found_q <= '0;
      status_q <= altbl_pkg::StatusOk;
      rd_is_j_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        altbl_pkg::OpLatch: begin
          kind_q <= kind_i;
          cnt_q <= '0;
          found_q <= '0;
          w_q <= '0;
          status_q <= (kind_i == altbl_pkg::KindFind) ? altbl_pkg::StatusNotFound
                                                       : altbl_pkg::StatusOk;
        end
        altbl_pkg::OpJInit: j_q <= (kind_q == altbl_pkg::KindInsert) ? len_q
                               : (kind_q == altbl_pkg::KindDelete) ? LW'(pos_q)
                               : '0;
        altbl_pkg::OpKInit: k_q <= '0;
        altbl_pkg::OpRdJ: rd_is_j_q <= 1'b1;
        altbl_pkg::OpRdK: rd_is_j_q <= 1'b0;
        altbl_pkg::OpJDec: j_q <= j_q - 1'b1;
        altbl_pkg::OpJInc: j_q <= j_q + 1'b1;
        altbl_pkg::OpKInc: k_q <= k_q + 1'b1;
        altbl_pkg::OpWrBack: begin
          if (kind_q == altbl_pkg::KindDedup || kind_q == altbl_pkg::KindRangeDel)
            w_q <= w_q + 1'b1;
        end
        altbl_pkg::OpWrVal: len_q <= len_q + 1'b1;
        altbl_pkg::OpCmpScan: begin
          if (rdata == vkey_q) begin
            status_q <= altbl_pkg::StatusOk;
            found_q <= j_q;
          end
        end
        altbl_pkg::OpCmpRange: if (in_range) cnt_q <= cnt_q + 1'b1;
        altbl_pkg::OpFinish: begin
          case (kind_q)
            altbl_pkg::KindInsert: begin
              if (len_q >= LW'(Depth)) status_q <= altbl_pkg::StatusFull;
              else if (pos_q == '0 || pos_q > len_ext + 1'b1)
                status_q <= altbl_pkg::StatusBadPos;
            end
            altbl_pkg::KindDelete: begin
              if (pos_q == '0 || pos_q > len_ext) status_q <= altbl_pkg::StatusBadPos;
              else len_q <= len_q - 1'b1;
            end
            altbl_pkg::KindDedup, altbl_pkg::KindRangeDel: len_q <= w_q;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Held entry: latched from the read port after a j read, once cur_load_q marks the read data valid.
  logic cur_load_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cur_load_q <= 1'b0;
    else cur_load_q <= (cmd_i.op == altbl_pkg::OpRdJ);
  end
  always_ff @(posedge clk_i) begin
    if (cur_load_q && rd_is_j_q) cur_q <= rdata;
    if (cmd_i.op == altbl_pkg::OpLatch) begin
      pos_q <= PW'(position_i);
      vkey_q <= ValueWidth'(value_i);
      lo_q <= value_i;
      hi_q <= range_high_i;
    end
  end

  always_comb begin
    sts_o.kind = kind_q;
    sts_o.full = len_q >= LW'(Depth);
    sts_o.pos_bad_ins = (pos_q == '0) || (pos_q > len_ext + 1'b1);
    sts_o.pos_bad_del = (pos_q == '0) || (pos_q > len_ext);
    case (kind_q)
      altbl_pkg::KindInsert: sts_o.j_done = (PW'(j_q) < pos_q);
      altbl_pkg::KindDelete: sts_o.j_done = (j_q >= len_q);
      default:               sts_o.j_done = (j_q >= len_q);
    endcase
    sts_o.k_done = (k_q >= w_q);
    // Find matches the search value, range delete the range, dedup the held entry.
    case (kind_q)
      altbl_pkg::KindFind:     sts_o.match = (rdata == vkey_q);
      altbl_pkg::KindRangeDel: sts_o.match = in_range;
      default:                 sts_o.match = (rdata == cur_q);
    endcase
  end

  assign status_o = status_q;
  assign found_index_o = altbl_pkg::IndexWidth'(found_q);
  assign range_count_o = altbl_pkg::CountWidth'(cnt_q);
  assign list_length_o = altbl_pkg::CountWidth'(len_q);
endmodule
`default_nettype wire

// ===== src/altbl_ctrl.sv =====
// Controller: sequences the datapath through each list command.
`default_nettype none
module altbl_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire altbl_pkg::dp_status_t sts_i,
  output altbl_pkg::dp_cmd_t         cmd_o
);
  typedef enum logic [3:0] {
    StIdle, StCheck, StInit, StLoop, StRead, StWait, StAct,
    StKRead, StKWait, StKCmp, StWrVal, StFinish, StDone
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  assign in_ready_o = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op = altbl_pkg::OpNone;
    case (state_q)
      StIdle: if (in_valid_i && in_ready_o) begin
        cmd_o.op = altbl_pkg::OpLatch;
        state_d = StCheck;
      end
      StCheck: begin
        state_d = StInit;
        case (sts_i.kind)
          altbl_pkg::KindInsert:
            if (sts_i.full || sts_i.pos_bad_ins) state_d = StFinish;
          altbl_pkg::KindDelete: if (sts_i.pos_bad_del) state_d = StFinish;
          altbl_pkg::KindFind, altbl_pkg::KindCount, altbl_pkg::KindDedup,
          altbl_pkg::KindRangeDel: ;
          default: state_d = StFinish;
        endcase
      end
      StInit: begin
        cmd_o.op = altbl_pkg::OpJInit;
        state_d = StLoop;
      end
      StLoop: begin
        if (sts_i.j_done)
          state_d = (sts_i.kind == altbl_pkg::KindInsert) ? StWrVal : StFinish;
        else begin
          cmd_o.op = altbl_pkg::OpRdJ;
          state_d = StWait;
        end
      end
      StWait: state_d = StAct;
      StAct: begin
        state_d = StLoop;
        case (sts_i.kind)
          altbl_pkg::KindInsert: cmd_o.op = altbl_pkg::OpWrBack;
          altbl_pkg::KindDelete: cmd_o.op = altbl_pkg::OpWrBack;
          altbl_pkg::KindFind: cmd_o.op = altbl_pkg::OpCmpScan;
          altbl_pkg::KindCount: cmd_o.op = altbl_pkg::OpCmpRange;
          altbl_pkg::KindDedup: begin
            cmd_o.op = altbl_pkg::OpKInit;
            state_d = StKRead;
          end
          default: state_d = StRead;
        endcase
        if (sts_i.kind != altbl_pkg::KindDedup && sts_i.kind != altbl_pkg::KindRangeDel)
          state_d = StRead;
      end
      // Advance the outer index after the action of the current entry.
      StRead: begin
        state_d = StLoop;
        case (sts_i.kind)
          altbl_pkg::KindInsert: cmd_o.op = altbl_pkg::OpJDec;
          altbl_pkg::KindFind: begin
            cmd_o.op = altbl_pkg::OpJInc;
            if (sts_i.match) state_d = StFinish;
          end
          altbl_pkg::KindRangeDel: begin
            // Entry held in cur; keep it if outside the range.
            cmd_o.op = altbl_pkg::OpJInc;
            state_d = StKCmp;
          end
          default: cmd_o.op = altbl_pkg::OpJInc;
        endcase
      end
      StKRead: begin
        if (sts_i.k_done) begin
          cmd_o.op = altbl_pkg::OpWrBack;
          state_d = StRead;
        end else begin
          cmd_o.op = altbl_pkg::OpRdK;
          state_d = StKWait;
        end
      end
      StKWait: state_d = StKCmp;
      StKCmp: begin
        if (sts_i.kind == altbl_pkg::KindRangeDel) begin
          state_d = StLoop;
          if (!sts_i.match) cmd_o.op = altbl_pkg::OpWrBack;
        end else if (sts_i.match) state_d = StRead;
        else begin
          cmd_o.op = altbl_pkg::OpKInc;
          state_d = StKRead;
        end
      end
      StWrVal: begin
        cmd_o.op = altbl_pkg::OpWrVal;
        state_d = StDone;
      end
      StFinish: begin
        cmd_o.op = altbl_pkg::OpFinish;
        state_d = StDone;
      end
      StDone: begin
        out_valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule
`default_nettype wire

// ===== src/altbl_checker.sv =====
// Port-level checker for the list engine, bound to the top level.
`default_nettype none
module altbl_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic [altbl_pkg::StatusWidth-1:0] status_i,
  input wire logic [altbl_pkg::IndexWidth-1:0] found_index_i,
  input wire logic [altbl_pkg::CountWidth-1:0] range_count_i
);
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("item accepted while a result waits");
  a_no_ready_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i) else $error("second item taken");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(status_i))
    else $error("result dropped");
  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != altbl_pkg::StatusOk) |-> found_index_i == '0)
    else $error("found index without match");
  a_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != altbl_pkg::StatusOk) |-> range_count_i == '0)
    else $error("count on failed command");
endmodule

bind array_list_table_engine_top altbl_checker u_checker (
  .clk_i, .rst_ni,
  .in_valid_i(cmd_i.valid), .in_ready_i(cmd_i.ready),
  .out_valid_i(res_o.valid), .out_ready_i(res_o.ready),
  .status_i(res_o.status), .found_index_i(res_o.found_index),
  .range_count_i(res_o.range_count)
);
`default_nettype wire
